### design/central_gradient_surface_normal_unit_defines.svh
// Assertion helpers for the top-level design file.
`ifndef CENTRAL_GRADIENT_SURFACE_NORMAL_UNIT_DEFINES_SVH
`define CENTRAL_GRADIENT_SURFACE_NORMAL_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define CGSN_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define CGSN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/cgsn_pkg.sv
package cgsn_pkg;

    localparam int FRAC_BITS = 15;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int T2_W      = 2 * Q_W;
    localparam logic [Q_W-1:0]       Q_ONE = Q_W'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS-1:0] Q_CAP = {FRAC_BITS{1'b1}};

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PIXEL_KIND   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_CALC,
        ST_NEXT,
        ST_NORM,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SQ,
        N_SUM,
        N_T,
        N_MUL,
        N_CMP
    } norm_state_t;

    typedef struct packed {
        logic [FRAC_BITS-1:0] qx;
        logic [FRAC_BITS-1:0] qy;
        logic [FRAC_BITS-1:0] qz;
    } norm_res_t;

endpackage

### design/central_gradient_surface_normal_unit.sv
// Central-difference gradient and surface normal for a raster pixel stream.
// Input channel: pixel_value and frame_start, accepted when in_valid is high
// and in_stall is low. Output channel: one transaction per result, accepted
// when out_valid is high and out_stall is low; run_last marks the last
// result of an input transaction, frame_last the frame's final pixel.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data),
// which the user must write only while no transaction is in flight; the
// block itself does not enforce this. One input is processed at a time:
// line store access and arithmetic (RD0, RD1, CALC), then a dispatch state
// (NEXT) before each result and once at the end. For each result the normal
// unit computes three components, one result bit at a time in the shared
// multiply and compare datapath; then the result waits in the output
// register until taken. An input causes zero to three results, and the
// next input is taken once the block has returned to its idle state.
// While the receiver stalls, the result holds and no input is taken.
// Reset clears counters, the recent-pixel history and the registers to
// width 640, height 480, 16-bit depth; line stores are not cleared.
module central_gradient_surface_normal_unit #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [15:0]                   pixel_value,
    input  logic                          frame_start,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [$clog2(MAX_HEIGHT)-1:0] out_row,
    output logic [$clog2(MAX_WIDTH)-1:0]  out_col,
    output logic signed [16:0]            diff_x,
    output logic signed [16:0]            diff_y,
    output logic signed [15:0]            normal_x,
    output logic signed [15:0]            normal_y,
    output logic [14:0]                   normal_z,
    output logic                          run_last,
    output logic                          frame_last,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [12:0]                   cfg_data
);

`include "central_gradient_surface_normal_unit_defines.svh"

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    cgsn_pkg::ctrl_state_t st_reg, st_next;

    logic [11:0]      cfg_width_reg;
    logic [12:0]      cfg_height_reg;
    logic             cfg_kind_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic [15:0]      rp0_reg, rp1_reg;

    logic [ROW_W-1:0] r_cur_reg;
    logic [COL_W-1:0] c_cur_reg;
    logic [15:0]      pix_reg;
    logic [15:0]      older_c_reg, newer_c_reg;

    logic [2:0]        pend_reg;
    logic [ROW_W-1:0]  res_row_reg [3];
    logic [COL_W-1:0]  res_col_reg [3];
    logic signed [16:0] res_dx_reg [3];
    logic signed [16:0] res_dy_reg [3];

    logic [ROW_W-1:0]   o_row_reg;
    logic [COL_W-1:0]   o_col_reg;
    logic signed [16:0] o_dx_reg, o_dy_reg;
    logic signed [15:0] o_nx_reg, o_ny_reg;
    logic [14:0]        o_nz_reg;
    logic               o_rlast_reg, o_flast_reg;
    logic [1:0]         sel_reg;

    logic             in_acc;
    logic [31:0]      w_eff, h_eff;
    logic             last_row, last_col;
    logic [COL_W-1:0] older_raddr, newer_raddr;
    logic [15:0]      older_rdata, newer_rdata;
    logic             ram_we;
    logic [1:0]       sel;
    logic [2:0]       sel_mask;
    logic [15:0]      mag_x, mag_y;
    logic             norm_start, norm_done;
    cgsn_pkg::norm_res_t norm_res;

    function automatic logic signed [16:0] sdiff(input logic [15:0] a, input logic [15:0] b);
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    function automatic logic [15:0] magn(input logic signed [16:0] d);
        logic [16:0] m;
        m = d[16] ? 17'(-d) : 17'(d);
        return m[15:0];
    endfunction

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (st_reg != cgsn_pkg::ST_IDLE);

    always_comb
    begin
        w_eff = 32'(cfg_width_reg);
        if (w_eff < 32'd3) w_eff = 32'd3;
        if (w_eff > 32'(MAX_WIDTH)) w_eff = 32'(MAX_WIDTH);
        h_eff = 32'(cfg_height_reg);
        if (h_eff < 32'd3) h_eff = 32'd3;
        if (h_eff > 32'(MAX_HEIGHT)) h_eff = 32'(MAX_HEIGHT);
        last_row = 32'(r_cur_reg) >= h_eff - 32'd1;
        last_col = 32'(c_cur_reg) >= w_eff - 32'd1;
    end

    always_comb
    begin
        if (st_reg == cgsn_pkg::ST_RD1)
        begin
            older_raddr = c_cur_reg - COL_W'(1);
            newer_raddr = c_cur_reg + COL_W'(1);
        end
        else
        begin
            older_raddr = c_cur_reg;
            newer_raddr = c_cur_reg;
        end
        ram_we = (st_reg == cgsn_pkg::ST_CALC);
    end

    cgsn_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_line_older (
        .clk   (clk),
        .we    (ram_we),
        .waddr (c_cur_reg),
        .wdata (newer_c_reg),
        .raddr (older_raddr),
        .rdata (older_rdata)
    );

    cgsn_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_line_newer (
        .clk   (clk),
        .we    (ram_we),
        .waddr (c_cur_reg),
        .wdata (pix_reg),
        .raddr (newer_raddr),
        .rdata (newer_rdata)
    );

    // Lowest pending result goes out first.
    always_comb
    begin
        if (pend_reg[0])      sel = 2'd0;
        else if (pend_reg[1]) sel = 2'd1;
        else                  sel = 2'd2;
        sel_mask   = 3'b001 << sel;
        mag_x      = magn(res_dx_reg[sel]);
        mag_y      = magn(res_dy_reg[sel]);
        norm_start = (st_reg == cgsn_pkg::ST_NEXT) && (pend_reg != 3'b000);
    end

    cgsn_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .mag_x (mag_x),
        .mag_y (mag_y),
        .done  (norm_done),
        .res   (norm_res)
    );

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            cgsn_pkg::ST_IDLE: if (in_acc) st_next = cgsn_pkg::ST_RD0;
            cgsn_pkg::ST_RD0:  st_next = cgsn_pkg::ST_RD1;
            cgsn_pkg::ST_RD1:  st_next = cgsn_pkg::ST_CALC;
            cgsn_pkg::ST_CALC: st_next = cgsn_pkg::ST_NEXT;
            cgsn_pkg::ST_NEXT:
            begin
                st_next = (pend_reg == 3'b000) ? cgsn_pkg::ST_IDLE : cgsn_pkg::ST_NORM;
            end
            cgsn_pkg::ST_NORM: if (norm_done) st_next = cgsn_pkg::ST_OUT;
            cgsn_pkg::ST_OUT:  if (!out_stall) st_next = cgsn_pkg::ST_NEXT;
            default:           st_next = cgsn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= cgsn_pkg::ST_IDLE;
            cfg_width_reg  <= 12'd640;
            cfg_height_reg <= 13'd480;
            cfg_kind_reg   <= 1'b1;
            row_reg        <= '0;
            col_reg        <= '0;
            rp0_reg        <= '0;
            rp1_reg        <= '0;
            pend_reg       <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    cgsn_pkg::REG_FRAME_WIDTH:  cfg_width_reg  <= cfg_data[11:0];
                    cgsn_pkg::REG_FRAME_HEIGHT: cfg_height_reg <= cfg_data;
                    cgsn_pkg::REG_PIXEL_KIND:   cfg_kind_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
            if (st_reg == cgsn_pkg::ST_CALC)
            begin
                pend_reg[0] <= r_cur_reg != '0;
                pend_reg[1] <= last_row && c_cur_reg != '0;
                pend_reg[2] <= last_row && last_col;
                rp1_reg     <= rp0_reg;
                rp0_reg     <= pix_reg;
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : r_cur_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= c_cur_reg + COL_W'(1);
                    row_reg <= r_cur_reg;
                end
            end
            else if (st_reg == cgsn_pkg::ST_OUT && !out_stall)
            begin
                pend_reg <= pend_reg & ~sel_mask;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            r_cur_reg <= frame_start ? '0 : row_reg;
            c_cur_reg <= frame_start ? '0 : col_reg;
            pix_reg   <= cfg_kind_reg ? pixel_value : {8'b0, pixel_value[7:0]};
        end
        if (st_reg == cgsn_pkg::ST_RD1)
        begin
            older_c_reg <= older_rdata;
            newer_c_reg <= newer_rdata;
        end
        if (st_reg == cgsn_pkg::ST_CALC)
        begin
            // Above the current row the newer store still holds the previous row
            // to the right, and the older store already holds it to the left.
            res_row_reg[0] <= r_cur_reg - ROW_W'(1);
            res_col_reg[0] <= c_cur_reg;
            res_dx_reg[0]  <= (c_cur_reg != '0 && !last_col
                               && 32'(c_cur_reg) + 32'd1 < 32'(MAX_WIDTH))
                              ? sdiff(newer_rdata, older_rdata) : 17'sd0;
            res_dy_reg[0]  <= (r_cur_reg > ROW_W'(1)) ? sdiff(pix_reg, older_c_reg) : 17'sd0;
            res_row_reg[1] <= r_cur_reg;
            res_col_reg[1] <= c_cur_reg - COL_W'(1);
            res_dx_reg[1]  <= (c_cur_reg > COL_W'(1)) ? sdiff(pix_reg, rp1_reg) : 17'sd0;
            res_dy_reg[1]  <= 17'sd0;
            res_row_reg[2] <= r_cur_reg;
            res_col_reg[2] <= c_cur_reg;
            res_dx_reg[2]  <= 17'sd0;
            res_dy_reg[2]  <= 17'sd0;
        end
        if (norm_start)
        begin
            sel_reg     <= sel;
            o_row_reg   <= res_row_reg[sel];
            o_col_reg   <= res_col_reg[sel];
            o_dx_reg    <= res_dx_reg[sel];
            o_dy_reg    <= res_dy_reg[sel];
            o_rlast_reg <= (pend_reg & ~sel_mask) == 3'b000;
            o_flast_reg <= sel == 2'd2;
        end
        if (st_reg == cgsn_pkg::ST_NORM && norm_done)
        begin
            o_nx_reg <= (o_dx_reg > 17'sd0) ? 16'(17'h10000 - {2'b0, norm_res.qx})
                                            : {1'b0, norm_res.qx};
            o_ny_reg <= (o_dy_reg > 17'sd0) ? 16'(17'h10000 - {2'b0, norm_res.qy})
                                            : {1'b0, norm_res.qy};
            o_nz_reg <= norm_res.qz;
        end
    end

    assign out_valid  = (st_reg == cgsn_pkg::ST_OUT);
    assign out_row    = o_row_reg;
    assign out_col    = o_col_reg;
    assign diff_x     = o_dx_reg;
    assign diff_y     = o_dy_reg;
    assign normal_x   = o_nx_reg;
    assign normal_y   = o_ny_reg;
    assign normal_z   = o_nz_reg;
    assign run_last   = o_rlast_reg;
    assign frame_last = o_flast_reg;

    `CGSN_ASSERT_IMPLY(a_accept_no_result, in_acc, !out_valid, "input taken while a result is pending")
    `CGSN_ASSERT_NEXT(a_one_item, in_acc, in_stall, "second input taken before the first finished")
    `CGSN_ASSERT_IMPLY(a_flast_is_last, out_valid && frame_last, run_last, "frame_last result is not the last of its input")
    `CGSN_ASSERT_IMPLY(a_flat_z_slot, out_valid && frame_last, sel_reg == 2'd2 && diff_x == 17'sd0, "final pixel result has wrong source")

endmodule

### design/cgsn_ram.sv
module cgsn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/cgsn_norm.sv
// Computes round(a * 2^F / sqrt(s)) for x, y and z, one result bit at a time.
module cgsn_norm (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [15:0]         mag_x,
    input  logic [15:0]         mag_y,
    output logic                done,
    output cgsn_pkg::norm_res_t res
);

    localparam int QW = cgsn_pkg::Q_W;
    localparam int TW = cgsn_pkg::T2_W;

    cgsn_pkg::norm_state_t st_reg, st_next;

    logic [15:0]      ax_reg, ay_reg;
    logic [31:0]      a2x_reg, a2y_reg;
    logic [32:0]      s_reg;
    logic [1:0]       comp_reg;
    logic [4:0]       bit_reg;
    logic [QW-1:0]    q_reg, cand_reg;
    logic             cand_ok_reg;
    logic [TW-1:0]    t2_reg;
    logic [TW+16:0]   plo_reg;
    logic [TW+15:0]   phi_reg;
    logic [cgsn_pkg::FRAC_BITS-1:0] qx_reg, qy_reg, qz_reg;
    logic             done_reg;

    logic [QW-1:0]    cand;
    logic [QW:0]      t_full;
    logic [QW-1:0]    t;
    logic [31:0]      asel;
    logic [65:0]      prod, rhs;
    logic [QW-1:0]    q_new;
    logic [cgsn_pkg::FRAC_BITS-1:0] q_fin;

    always_comb
    begin
        cand   = q_reg | (QW'(1) << bit_reg);
        t_full = {cand, 1'b0} - (QW+1)'(1);
        t      = t_full[QW-1:0];
        case (comp_reg)
            2'd0:    asel = a2x_reg;
            2'd1:    asel = a2y_reg;
            default: asel = 32'd4;
        endcase
        prod  = {phi_reg, 17'b0} + 66'(plo_reg);
        rhs   = {2'b0, asel, 32'b0};
        q_new = (cand_ok_reg && prod <= rhs) ? cand_reg : q_reg;
        q_fin = (q_new > QW'(cgsn_pkg::Q_CAP)) ? cgsn_pkg::Q_CAP
                                              : q_new[cgsn_pkg::FRAC_BITS-1:0];
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            cgsn_pkg::N_IDLE: if (start) st_next = cgsn_pkg::N_SQ;
            cgsn_pkg::N_SQ:   st_next = cgsn_pkg::N_SUM;
            cgsn_pkg::N_SUM:  st_next = cgsn_pkg::N_T;
            cgsn_pkg::N_T:    st_next = cgsn_pkg::N_MUL;
            cgsn_pkg::N_MUL:  st_next = cgsn_pkg::N_CMP;
            cgsn_pkg::N_CMP:
            begin
                if (bit_reg == 5'd0 && comp_reg == 2'd2)
                begin
                    st_next = cgsn_pkg::N_IDLE;
                end
                else
                begin
                    st_next = cgsn_pkg::N_T;
                end
            end
            default:          st_next = cgsn_pkg::N_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= cgsn_pkg::N_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= (st_reg == cgsn_pkg::N_CMP) && bit_reg == 5'd0 && comp_reg == 2'd2;
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            cgsn_pkg::N_IDLE:
            begin
                if (start)
                begin
                    ax_reg <= mag_x;
                    ay_reg <= mag_y;
                end
            end
            cgsn_pkg::N_SQ:
            begin
                a2x_reg <= ax_reg * ax_reg;
                a2y_reg <= ay_reg * ay_reg;
            end
            cgsn_pkg::N_SUM:
            begin
                s_reg    <= 33'(a2x_reg) + 33'(a2y_reg) + 33'd4;
                comp_reg <= 2'd0;
                bit_reg  <= 5'(cgsn_pkg::FRAC_BITS);
                q_reg    <= '0;
            end
            cgsn_pkg::N_T:
            begin
                cand_reg    <= cand;
                cand_ok_reg <= cand <= cgsn_pkg::Q_ONE;
                t2_reg      <= t * t;
            end
            cgsn_pkg::N_MUL:
            begin
                plo_reg <= t2_reg * s_reg[16:0];
                phi_reg <= t2_reg * s_reg[32:17];
            end
            cgsn_pkg::N_CMP:
            begin
                if (bit_reg == 5'd0)
                begin
                    case (comp_reg)
                        2'd0:    qx_reg <= q_fin;
                        2'd1:    qy_reg <= q_fin;
                        default: qz_reg <= q_fin;
                    endcase
                    comp_reg <= comp_reg + 2'd1;
                    bit_reg  <= 5'(cgsn_pkg::FRAC_BITS);
                    q_reg    <= '0;
                end
                else
                begin
                    bit_reg <= bit_reg - 5'd1;
                    q_reg   <= q_new;
                end
            end
            default: ;
        endcase
    end

    assign done   = done_reg;
    assign res.qx = qx_reg;
    assign res.qy = qy_reg;
    assign res.qz = qz_reg;

endmodule

### sim/tb.sv
module tb;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] pixel_value = '0;
    logic        frame_start = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [11:0] out_row;
    logic [10:0] out_col;
    logic signed [16:0] diff_x;
    logic signed [16:0] diff_y;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic [14:0] normal_z;
    logic        run_last;
    logic        frame_last;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = cgsn_pkg::REG_FRAME_WIDTH;
    logic [12:0] cfg_data = '0;

    central_gradient_surface_normal_unit dut (.*);

    always #1 clk = ~clk;

    typedef struct {
        logic [11:0] row;
        logic [10:0] col;
        logic [16:0] dx;
        logic [16:0] dy;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [14:0] nz;
        logic        rl;
        logic        fl;
    } gradient_result_t;

    class gradient_scoreboard;
        logic [15:0] older_row [2048];
        logic [15:0] newer_row [2048];
        int unsigned row_cnt, col_cnt;
        logic [15:0] prev1 = '0, prev0 = '0;
        int unsigned width_reg = 640, height_reg = 480, kind_reg = 1;
        gradient_result_t pending[$];
        int errors, pixels, results, frames;

        function void set_reg(logic [1:0] idx, logic [12:0] val);
            if (idx == cgsn_pkg::REG_FRAME_WIDTH) width_reg = val[11:0];
            else if (idx == cgsn_pkg::REG_FRAME_HEIGHT) height_reg = val;
            else if (idx == cgsn_pkg::REG_PIXEL_KIND) kind_reg = val[0];
        endfunction

        // Round-half-up of a * 2^15 / sqrt(s): largest q with (2q-1)^2 * s <= (2a * 2^15)^2.
        function int unsigned unit_ratio(longint unsigned a, longint unsigned s);
            logic [127:0] num, lim, t, prod;
            longint unsigned lo, hi, mid;
            num = 128'(2 * a) << 15;
            lim = num * num;
            lo = 0;
            hi = 32768;
            while (lo < hi)
            begin
                mid = (lo + hi + 1) / 2;
                t = 128'(2 * mid - 1);
                prod = t * t * 128'(s);
                if (prod <= lim) lo = mid;
                else hi = mid - 1;
            end
            if (lo > 32767) lo = 32767;
            return lo;
        endfunction

        function void add_result(int unsigned r, int unsigned c, int dx, int dy, bit fl);
            gradient_result_t e;
            longint unsigned ax, ay, s;
            int unsigned qx, qy;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            s = ax * ax + ay * ay + 4;
            qx = unit_ratio(ax, s);
            qy = unit_ratio(ay, s);
            e.row = r[11:0];
            e.col = c[10:0];
            e.dx = dx[16:0];
            e.dy = dy[16:0];
            e.nx = (dx > 0) ? 16'(32'h10000 - qx) : 16'(qx);
            e.ny = (dy > 0) ? 16'(32'h10000 - qy) : 16'(qy);
            e.nz = 15'(unit_ratio(2, s));
            e.rl = 1'b0;
            e.fl = fl;
            pending.insert(pending.size(), e);
        endfunction

        function void note_pixel(logic [15:0] value, logic fs);
            int unsigned w, h, r, c, prior_cnt;
            logic [15:0] p;
            bit lrow, lcol;
            int dx, dy;
            w = width_reg;
            h = height_reg;
            if (w < 3) w = 3;
            if (w > 2048) w = 2048;
            if (h < 3) h = 3;
            if (h > 4096) h = 4096;
            if (fs)
            begin
                row_cnt = 0;
                col_cnt = 0;
            end
            r = row_cnt;
            c = (col_cnt > 2047) ? 2047 : col_cnt;
            p = kind_reg ? value : {8'h00, value[7:0]};
            lrow = r >= h - 1;
            lcol = c >= w - 1;
            prior_cnt = pending.size();
            pixels++;
            if (r >= 1)
            begin
                dx = 0;
                dy = 0;
                if (c >= 1 && !lcol && c + 1 < 2048)
                    dx = int'(newer_row[c + 1]) - int'(older_row[c - 1]);
                if (r >= 2)
                    dy = int'(p) - int'(older_row[c]);
                add_result(r - 1, c, dx, dy, 1'b0);
            end
            if (lrow && c >= 1)
            begin
                dx = (c >= 2) ? int'(p) - int'(prev1) : 0;
                add_result(r, c - 1, dx, 0, 1'b0);
            end
            if (lrow && lcol)
                add_result(r, c, 0, 0, 1'b1);
            if (pending.size() > prior_cnt)
                pending[pending.size() - 1].rl = 1'b1;
            older_row[c] = newer_row[c];
            newer_row[c] = p;
            prev1 = prev0;
            prev0 = p;
            if (lcol)
            begin
                col_cnt = 0;
                row_cnt = lrow ? 0 : r + 1;
            end
            else
                col_cnt = c + 1;
        endfunction

        function void check_result(gradient_result_t got);
            gradient_result_t e;
            results++;
            if (got.fl) frames++;
            if (pending.size() == 0)
            begin
                $error("unexpected result row %0d col %0d", got.row, got.col);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.row !== e.row) begin $error("out_row exp %0d got %0d", e.row, got.row); errors++; end
            if (got.col !== e.col) begin $error("out_col exp %0d got %0d", e.col, got.col); errors++; end
            if (got.dx !== e.dx) begin $error("diff_x exp %h got %h", e.dx, got.dx); errors++; end
            if (got.dy !== e.dy) begin $error("diff_y exp %h got %h", e.dy, got.dy); errors++; end
            if (got.nx !== e.nx) begin $error("normal_x exp %h got %h", e.nx, got.nx); errors++; end
            if (got.ny !== e.ny) begin $error("normal_y exp %h got %h", e.ny, got.ny); errors++; end
            if (got.nz !== e.nz) begin $error("normal_z exp %h got %h", e.nz, got.nz); errors++; end
            if (got.rl !== e.rl) begin $error("run_last exp %b got %b", e.rl, got.rl); errors++; end
            if (got.fl !== e.fl) begin $error("frame_last exp %b got %b", e.fl, got.fl); errors++; end
        endfunction
    endclass

    gradient_scoreboard sb = new();

    int  cycle_cnt = 0;
    int  burst_left = 0;
    bit  hold_req = 0;
    int  hold_cnt = 0;

    // Receiver: a stall pattern that cycles through four modes, plus one long hold-off.
    always @(posedge clk)
    begin
        gradient_result_t got;
        bit st;
        int mode;
        cycle_cnt++;
        if (cycle_cnt > 2000000)
        begin
            $display("FAIL");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            got.row = out_row;
            got.col = out_col;
            got.dx = diff_x;
            got.dy = diff_y;
            got.nx = normal_x;
            got.ny = normal_y;
            got.nz = normal_z;
            got.rl = run_last;
            got.fl = frame_last;
            sb.check_result(got);
        end
        mode = (cycle_cnt / 64) % 4;
        if (hold_cnt > 0)
        begin
            st = 1;
            hold_cnt--;
        end
        else if (hold_req)
        begin
            st = 1;
            hold_cnt = 3000;
            hold_req = 0;
        end
        else if (mode == 0)
            st = 0;
        else if (mode == 1)
            st = ($urandom_range(0, 2) == 0);
        else if (mode == 2)
            st = cycle_cnt[0];
        else
            st = ($urandom_range(0, 7) != 0);
        out_stall <= st;
    end

    task automatic send_pixel(logic [15:0] value, logic fs);
        int gap;
        pixel_value <= value;
        frame_start <= fs;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_pixel(value, fs);
        if (burst_left > 0) burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stops offering pixels until every expected result has arrived, then lets
    // the block finish any work that produces no result.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (500) @(posedge clk);
    endtask

    task automatic set_config(logic [12:0] w, logic [12:0] h, logic [12:0] k);
        cfg_wr_en <= 1'b1;
        cfg_index <= cgsn_pkg::REG_FRAME_WIDTH;
        cfg_data <= w;
        sb.set_reg(cgsn_pkg::REG_FRAME_WIDTH, w);
        @(posedge clk);
        cfg_index <= cgsn_pkg::REG_FRAME_HEIGHT;
        cfg_data <= h;
        sb.set_reg(cgsn_pkg::REG_FRAME_HEIGHT, h);
        @(posedge clk);
        cfg_index <= cgsn_pkg::REG_PIXEL_KIND;
        cfg_data <= k;
        sb.set_reg(cgsn_pkg::REG_PIXEL_KIND, k);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] rand_pixel();
        int sel;
        sel = $urandom_range(0, 3);
        if (sel == 0) return 16'h0000;
        if (sel == 1) return 16'hffff;
        return 16'($urandom);
    endfunction

    initial
    begin
        int w, h, weff, heff, n;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Widest clamped width, smallest clamped height, gray pixels: a partial first row.
        set_config(13'h0fff, 13'd0, 13'd0);
        for (int i = 0; i < 5; i++) send_pixel(i[0] ? 16'hffff : 16'h1234, i == 0);
        drain();
        // Smallest frame with extreme samples, including a flat region.
        set_config(13'd3, 13'd3, 13'd1);
        send_pixel(16'h0000, 1'b1);
        send_pixel(16'hffff, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'hffff, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'hffff, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h7777, 1'b0);
        send_pixel(16'h7777, 1'b0);
        drain();
        // Height clamped to its maximum; only the first rows are sent.
        set_config(13'd3, 13'h1fff, 13'd1);
        for (int i = 0; i < 6; i++) send_pixel(16'h5555, i == 0);
        drain();
        // Shrinking the size in the middle of a frame ends the row and the frame early.
        set_config(13'd6, 13'd5, 13'd1);
        for (int i = 0; i < 9; i++) send_pixel(rand_pixel(), i == 0);
        drain();
        set_config(13'd3, 13'd3, 13'd1);
        for (int i = 0; i < 4; i++) send_pixel(rand_pixel(), 1'b0);
        drain();

        hold_req = 1;
        n = 0;
        while (n < 245)
        begin
            w = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
            h = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
            if (n > 0 && $urandom_range(0, 3) != 0)
            begin
                drain();
                set_config(13'(w), 13'(h), 13'($urandom_range(0, 1)));
            end
            weff = (sb.width_reg < 3) ? 3 : sb.width_reg;
            heff = (sb.height_reg < 3) ? 3 : sb.height_reg;
            for (int i = 0; i < weff * heff && n < 245; i++)
            begin
                // Now and then a stray frame start restarts the frame.
                send_pixel(rand_pixel(), i == 0 || $urandom_range(0, 60) == 0);
                n++;
            end
        end
        drain();

        $display("Sent %0d pixels; checked %0d results over %0d completed frames.",
                 sb.pixels, sb.results, sb.frames);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
